### design/tcc_pkg.sv
// Shared types, codes and helpers for the text console cursor engine.
// No dependencies.
`default_nettype none
package tcc_pkg;

  localparam int CellW = 12;
  localparam int CellH = 16;
  localparam int MarkH = 2;
  localparam int QueueDepth = 4;
  localparam int DefFrameWidth = 640;
  localparam int DefFrameHeight = 480;

  localparam logic [23:0] COLOR_BG = 24'h000000;
  localparam logic [23:0] COLOR_FG = 24'hFFFFFF;
  localparam logic [19:0] BLINK_RESET = 20'd500000;

  localparam logic [3:0] MODE_PUTCHAR = 4'd0;
  localparam logic [3:0] MODE_BACKSP = 4'd1;
  localparam logic [3:0] MODE_SETPOS = 4'd2;
  localparam logic [3:0] MODE_CLEAR = 4'd3;
  localparam logic [3:0] MODE_CLRLINE = 4'd4;
  localparam logic [3:0] MODE_ENABLE = 4'd5;
  localparam logic [3:0] MODE_SHOW = 4'd6;
  localparam logic [3:0] MODE_HIDE = 4'd7;
  localparam logic [3:0] MODE_TICK = 4'd8;
  localparam logic [3:0] MODE_SUSPEND = 4'd9;
  localparam logic [3:0] MODE_RESUME = 4'd10;

  localparam logic [2:0] CMD_FILL = 3'd0;
  localparam logic [2:0] CMD_GLYPH = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_PRESENT = 3'd3;
  localparam logic [2:0] CMD_SERIAL = 3'd4;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_BLINK = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN = 8'd13;
  localparam logic [7:0] CH_BACKSP = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Result slots, in emission order.
  localparam int NumSlots = 10;
  localparam int SlotSer = 0;
  localparam int SlotErase = 1;
  localparam int SlotBs1 = 2;
  localparam int SlotBs2 = 3;
  localparam int SlotBs3 = 4;
  localparam int SlotGlyph = 5;
  localparam int SlotClear = 6;
  localparam int SlotFill = 7;
  localparam int SlotDraw = 8;
  localparam int SlotPresent = 9;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [7:0]  ch;
    logic [7:0]  er_col;
    logic [7:0]  er_row;
    logic [7:0]  gl_col;
    logic [7:0]  gl_row;
    logic [11:0] fill_x;
    logic [11:0] fill_y;
    logic [11:0] fill_w;
    logic [4:0]  fill_h;
    logic [7:0]  fin_col;
    logic [7:0]  fin_row;
  } tcc_job_t;

  function automatic logic [11:0] cell_x(input logic [7:0] col);
    logic [11:0] t;
    t = {4'b0, col};
    return (t << 3) + (t << 2);
  endfunction

  function automatic logic [11:0] cell_y(input logic [7:0] row);
    return {row, 4'b0};
  endfunction

  function automatic logic [11:0] mark_y(input logic [7:0] row);
    return {row, 4'b0} + 12'(CellH - MarkH);
  endfunction

endpackage
`default_nettype wire

### design/text_console_cursor_engine.sv
// Text console cursor engine: top level joining front end, job queue and back end.
// Depends on tcc_pkg, tcc_front, tcc_queue, tcc_back.
//
// Each accepted command item updates the cursor state in the cycle it is taken
// and, if it has any results, leaves a job in a four-entry queue; the back end
// turns each job into its draw commands (fill, glyph, clear, present, serial
// byte), one result per cycle while the receiver is ready, through a registered
// output. An item is taken every cycle while the queue has room, so the sustained
// rate is set by the output: a command has one to seven results (seven for a
// backspace that moves the cursor, six at most for putchar), or none. The output
// fields cur_col and cur_row carry the cursor cell after the whole command; last
// marks its final result. Configuration writes (columns, rows, blink period) take
// effect on the next item; a column or row count of zero acts as one.
`default_nettype none
module text_console_cursor_engine import tcc_pkg::*; #(
  parameter int FRAME_WIDTH = DefFrameWidth,
  parameter int FRAME_HEIGHT = DefFrameHeight
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  mode,
  input  wire logic [7:0]  char_code,
  input  wire logic signed [15:0] pos_col,
  input  wire logic signed [15:0] pos_row,
  input  wire logic        enable_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       command,
  output logic [11:0]      pixel_x,
  output logic [11:0]      pixel_y,
  output logic [11:0]      rect_width,
  output logic [4:0]       rect_height,
  output logic [23:0]      color,
  output logic [7:0]       byte_out,
  output logic [7:0]       cur_col,
  output logic [7:0]       cur_row,
  output logic             last
);

  tcc_job_t job, head;
  logic     job_valid, full, pop, not_empty, take;

  // Take an item whenever the queue has room.
  assign in_ready = !full;
  assign take = in_valid && in_ready;

  tcc_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .mode       (mode),
    .char_code  (char_code),
    .pos_col    (pos_col),
    .pos_row    (pos_row),
    .enable_flag(enable_flag),
    .job        (job),
    .job_valid  (job_valid)
  );

  tcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty)
  );

  tcc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .command    (command),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .color      (color),
    .byte_out   (byte_out),
    .cur_col    (cur_col),
    .cur_row    (cur_row),
    .last       (last)
  );

endmodule
`default_nettype wire

### design/tcc_front.sv
// Front end: accepts command items, keeps cursor state and config, builds jobs.
// Depends on tcc_pkg.
`default_nettype none
module tcc_front import tcc_pkg::*; #(
  parameter int FRAME_WIDTH = DefFrameWidth,
  parameter int FRAME_HEIGHT = DefFrameHeight
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic        take,
  input  wire logic [3:0]  mode,
  input  wire logic [7:0]  char_code,
  input  wire logic signed [15:0] pos_col,
  input  wire logic signed [15:0] pos_row,
  input  wire logic        enable_flag,
  output tcc_job_t         job,
  output logic             job_valid
);

  logic [7:0]  text_columns, text_rows;
  logic [19:0] blink_period;
  logic [7:0]  cursor_col, cursor_row, mark_col, mark_row;
  logic        cursor_on, cursor_shown, mark_drawn, paused, saved_shown;
  logic [19:0] blink_count;

  logic [7:0]  cursor_col_next, cursor_row_next, mark_col_next, mark_row_next;
  logic        cursor_on_next, cursor_shown_next, mark_drawn_next;
  logic        paused_next, saved_shown_next;
  logic [19:0] blink_count_next;

  logic [7:0]  ncols, nrows;
  logic [19:0] period;
  logic [12:0] line_px;

  assign ncols  = (text_columns == 8'd0) ? 8'd1 : text_columns;
  assign nrows  = (text_rows == 8'd0) ? 8'd1 : text_rows;
  assign period = (blink_period == 20'd0) ? 20'd1 : blink_period;
  assign line_px = {1'b0, cell_x(cursor_col)};

  function automatic logic [7:0] clamp_cell(input logic signed [15:0] v,
                                            input logic [7:0] n);
    if (v < 0) return 8'd0;
    if ($unsigned(v) >= {8'd0, n}) return n - 8'd1;
    return v[7:0];
  endfunction

  always_comb begin
    tcc_job_t j;
    logic     do_erase, do_draw, do_newline;
    j = '0;
    do_erase = 1'b0;
    do_draw = 1'b0;
    do_newline = 1'b0;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    cursor_on_next = cursor_on;
    cursor_shown_next = cursor_shown;
    mark_drawn_next = mark_drawn;
    mark_col_next = mark_col;
    mark_row_next = mark_row;
    paused_next = paused;
    saved_shown_next = saved_shown;
    blink_count_next = blink_count;
    j.ch = char_code;
    j.er_col = mark_col;
    j.er_row = mark_row;
    j.gl_col = cursor_col;
    j.gl_row = cursor_row;

    case (mode)
      MODE_PUTCHAR: begin
        j.mask[SlotSer] = 1'b1;
        if (!paused) begin
          do_erase = 1'b1;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
          if (char_code == CH_NEWLINE) begin
            do_newline = 1'b1;
          end else if (char_code == CH_RETURN) begin
            cursor_col_next = 8'd0;
          end else begin
            j.mask[SlotGlyph] = 1'b1;
            cursor_col_next = cursor_col + 8'd1;
            if (cursor_col_next >= ncols) do_newline = 1'b1;
          end
        end
      end
      MODE_BACKSP: begin
        if (!paused) begin
          do_erase = 1'b1;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
          if (cursor_col != 8'd0) begin
            cursor_col_next = cursor_col - 8'd1;
            j.mask[SlotBs1] = 1'b1;
            j.mask[SlotBs2] = 1'b1;
            j.mask[SlotBs3] = 1'b1;
            j.mask[SlotFill] = 1'b1;
            j.fill_x = cell_x(cursor_col_next);
            j.fill_y = cell_y(cursor_row);
            j.fill_w = 12'(CellW);
            j.fill_h = 5'(CellH);
          end
        end
      end
      MODE_SETPOS: begin
        if (!paused) begin
          do_erase = 1'b1;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
          cursor_col_next = clamp_cell(pos_col, ncols);
          cursor_row_next = clamp_cell(pos_row, nrows);
        end
      end
      MODE_CLEAR: begin
        if (!paused) begin
          j.mask[SlotClear] = 1'b1;
          cursor_col_next = 8'd0;
          cursor_row_next = 8'd0;
          mark_drawn_next = 1'b0;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      MODE_CLRLINE: begin
        if (!paused) begin
          do_erase = 1'b1;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
          if (13'(FRAME_WIDTH) > line_px) begin
            j.mask[SlotFill] = 1'b1;
            j.fill_x = line_px[11:0];
            j.fill_y = cell_y(cursor_row);
            j.fill_w = 12'(13'(FRAME_WIDTH) - line_px);
            j.fill_h = 5'(CellH);
          end
        end
      end
      MODE_ENABLE: begin
        if (!paused) begin
          do_erase = 1'b1;
          cursor_on_next = enable_flag;
          cursor_shown_next = enable_flag;
          blink_count_next = '0;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      MODE_SHOW: begin
        if (!paused && cursor_on) begin
          do_erase = 1'b1;
          cursor_shown_next = 1'b1;
          blink_count_next = '0;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      MODE_HIDE: begin
        if (!paused) begin
          do_erase = 1'b1;
          cursor_shown_next = 1'b0;
          blink_count_next = '0;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      MODE_TICK: begin
        if (!paused && cursor_on) begin
          blink_count_next = blink_count + 20'd1;
          if (blink_count_next >= period) begin
            blink_count_next = '0;
            j.mask[SlotPresent] = 1'b1;
            if (cursor_shown) begin
              do_erase = 1'b1;
              cursor_shown_next = 1'b0;
            end else begin
              cursor_shown_next = 1'b1;
              do_draw = 1'b1;
            end
          end
        end
      end
      MODE_SUSPEND: begin
        if (!paused) begin
          do_erase = 1'b1;
          saved_shown_next = cursor_shown;
          cursor_shown_next = 1'b0;
          blink_count_next = '0;
          paused_next = 1'b1;
          cursor_col_next = 8'd0;
          cursor_row_next = 8'd0;
          j.mask[SlotClear] = 1'b1;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      MODE_RESUME: begin
        if (paused) begin
          paused_next = 1'b0;
          cursor_col_next = 8'd0;
          cursor_row_next = 8'd0;
          mark_drawn_next = 1'b0;
          blink_count_next = '0;
          cursor_shown_next = cursor_on && saved_shown;
          saved_shown_next = 1'b0;
          j.mask[SlotClear] = 1'b1;
          do_draw = 1'b1;
          j.mask[SlotPresent] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Erase the old underline if one is drawn; its slot comes before any glyph or new underline.
    if (do_erase && mark_drawn) begin
      if (mark_col < ncols && mark_row < nrows) j.mask[SlotErase] = 1'b1;
      mark_drawn_next = 1'b0;
    end

    // Running past the last row clears the screen and homes the cursor.
    if (do_newline) begin
      cursor_col_next = 8'd0;
      cursor_row_next = cursor_row + 8'd1;
      if (cursor_row_next >= nrows) begin
        j.mask[SlotClear] = 1'b1;
        cursor_row_next = 8'd0;
        mark_drawn_next = 1'b0;
      end
    end

    if (do_draw && cursor_on_next && cursor_shown_next) begin
      if (cursor_col_next < ncols && cursor_row_next < nrows) j.mask[SlotDraw] = 1'b1;
      mark_drawn_next = 1'b1;
      mark_col_next = cursor_col_next;
      mark_row_next = cursor_row_next;
    end

    j.fin_col = cursor_col_next;
    j.fin_row = cursor_row_next;
    job = j;
    job_valid = take && (j.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= 8'(FRAME_WIDTH / CellW);
      text_rows    <= 8'(FRAME_HEIGHT / CellH);
      blink_period <= BLINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: text_columns <= cfg_data[7:0];
        REG_ROWS:    text_rows <= cfg_data[7:0];
        REG_BLINK:   blink_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      cursor_on <= 1'b0;
      cursor_shown <= 1'b0;
      blink_count <= '0;
      mark_drawn <= 1'b0;
      mark_col <= '0;
      mark_row <= '0;
      paused <= 1'b0;
      saved_shown <= 1'b0;
    end else if (take) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      cursor_on <= cursor_on_next;
      cursor_shown <= cursor_shown_next;
      blink_count <= blink_count_next;
      mark_drawn <= mark_drawn_next;
      mark_col <= mark_col_next;
      mark_row <= mark_row_next;
      paused <= paused_next;
      saved_shown <= saved_shown_next;
    end
  end

endmodule
`default_nettype wire

### design/tcc_queue.sv
// Short job queue between the front and back ends.
// Depends on tcc_pkg.
`default_nettype none
module tcc_queue import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  tcc_job_t  push_job,
  output logic      full,
  input  wire logic pop,
  output tcc_job_t  head,
  output logic      not_empty
);

  localparam int PtrW = $clog2(QueueDepth);

  tcc_job_t        slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;

  assign full = (count == (PtrW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/tcc_back.sv
// Back end: walks a job's slot mask and emits one draw command per cycle while the receiver is ready.
// Depends on tcc_pkg.
`default_nettype none
module tcc_back import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  tcc_job_t  head,
  input  wire logic head_valid,
  output logic      pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [2:0]  command,
  output logic [11:0] pixel_x,
  output logic [11:0] pixel_y,
  output logic [11:0] rect_width,
  output logic [4:0]  rect_height,
  output logic [23:0] color,
  output logic [7:0]  byte_out,
  output logic [7:0]  cur_col,
  output logic [7:0]  cur_row,
  output logic        last
);

  tcc_job_t            cur;
  logic                cur_valid;
  logic [3:0]          sel;
  logic [NumSlots-1:0] rest;
  logic                load;

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (cur.mask[i]) sel = 4'(i);
    end
    rest = cur.mask & ~(NumSlots'(1) << sel);
  end

  assign load = cur_valid && (!out_valid || out_ready);
  assign pop = head_valid && (!cur_valid || (load && rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (load && rest == '0) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (load) begin
      cur.mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command <= CMD_FILL;
      pixel_x <= '0;
      pixel_y <= '0;
      rect_width <= '0;
      rect_height <= '0;
      color <= COLOR_BG;
      byte_out <= '0;
      cur_col <= cur.fin_col;
      cur_row <= cur.fin_row;
      last <= (rest == '0);
      case (sel)
        4'(SlotSer): begin
          command <= CMD_SERIAL;
          byte_out <= cur.ch;
        end
        4'(SlotErase): begin
          pixel_x <= cell_x(cur.er_col);
          pixel_y <= mark_y(cur.er_row);
          rect_width <= 12'(CellW);
          rect_height <= 5'(MarkH);
        end
        4'(SlotBs1), 4'(SlotBs3): begin
          command <= CMD_SERIAL;
          byte_out <= CH_BACKSP;
        end
        4'(SlotBs2): begin
          command <= CMD_SERIAL;
          byte_out <= CH_SPACE;
        end
        4'(SlotGlyph): begin
          command <= CMD_GLYPH;
          pixel_x <= cell_x(cur.gl_col);
          pixel_y <= cell_y(cur.gl_row);
          color <= COLOR_FG;
          byte_out <= cur.ch;
        end
        4'(SlotClear): command <= CMD_CLEAR;
        4'(SlotFill): begin
          pixel_x <= cur.fill_x;
          pixel_y <= cur.fill_y;
          rect_width <= cur.fill_w;
          rect_height <= cur.fill_h;
        end
        4'(SlotDraw): begin
          pixel_x <= cell_x(cur.fin_col);
          pixel_y <= mark_y(cur.fin_row);
          rect_width <= 12'(CellW);
          rect_height <= 5'(MarkH);
          color <= COLOR_FG;
        end
        4'(SlotPresent): command <= CMD_PRESENT;
        default: command <= CMD_PRESENT;
      endcase
    end
  end

endmodule
`default_nettype wire

### test/tcc_checker.sv
// Scoreboard for the text console cursor engine: watches config writes and both
// channels, predicts the draw command sequence and compares it. Depends on tcc_pkg.
module tcc_checker import tcc_pkg::*; #(
  parameter int FRAME_WIDTH = DefFrameWidth,
  parameter int FRAME_HEIGHT = DefFrameHeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  mode,
  input  logic [7:0]  char_code,
  input  logic signed [15:0] pos_col,
  input  logic signed [15:0] pos_row,
  input  logic        enable_flag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  command,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [11:0] rect_width,
  input  logic [4:0]  rect_height,
  input  logic [23:0] color,
  input  logic [7:0]  byte_out,
  input  logic [7:0]  cur_col,
  input  logic [7:0]  cur_row,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [4:0]  h;
    logic [23:0] color;
    logic [7:0]  byte_v;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        last;
  } draw_t;

  draw_t expected_draws[$];
  draw_t cmd_draws[$];

  logic [7:0]  columns_reg, rows_reg;
  logic [19:0] blink_reg;
  logic [7:0]  crs_col, crs_row, ul_col, ul_row;
  logic        saved_vis;
  logic        crs_enabled, crs_visible, ul_drawn, suspended;
  logic [19:0] blink_cnt;

  function automatic logic [7:0] cols_eff();
    return (columns_reg == 0) ? 8'd1 : columns_reg;
  endfunction

  function automatic logic [7:0] rows_eff();
    return (rows_reg == 0) ? 8'd1 : rows_reg;
  endfunction

  task automatic push_draw(logic [2:0] cmd, int x, int y, int w, int h, logic [23:0] c,
                           logic [7:0] b);
    draw_t d;
    d = '0;
    d.command = cmd;
    d.x = x[11:0];
    d.y = y[11:0];
    d.w = w[11:0];
    d.h = h[4:0];
    d.color = c;
    d.byte_v = b;
    cmd_draws.push_back(d);
  endtask

  // Underline cells off screen count as drawn but produce nothing.
  task automatic underline(logic [7:0] c, logic [7:0] r, logic [23:0] clr);
    if (c >= cols_eff() || r >= rows_eff()) return;
    push_draw(CMD_FILL, c * CellW, r * CellH + CellH - MarkH, CellW, MarkH, clr, 0);
  endtask

  task automatic erase_underline();
    if (!ul_drawn) return;
    underline(ul_col, ul_row, COLOR_BG);
    ul_drawn = 0;
  endtask

  task automatic draw_underline();
    if (!crs_enabled || !crs_visible) return;
    underline(crs_col, crs_row, COLOR_FG);
    ul_drawn = 1;
    ul_col = crs_col;
    ul_row = crs_row;
  endtask

  task automatic advance_line();
    crs_col = 0;
    crs_row = 8'(crs_row + 8'd1);
    if (crs_row >= rows_eff()) begin
      push_draw(CMD_CLEAR, 0, 0, 0, 0, COLOR_BG, 0);
      crs_row = 0;
      ul_drawn = 0;
    end
  endtask

  function automatic logic [7:0] clamp_cell(logic signed [15:0] v, logic [7:0] n);
    if (v < 0) return 8'd0;
    if (v >= $signed({8'b0, n})) return 8'(n - 8'd1);
    return v[7:0];
  endfunction

  task automatic predict_command(logic [3:0] m, logic [7:0] ch, logic signed [15:0] pc,
                                 logic signed [15:0] pr, logic en);
    int px;
    logic [19:0] per;
    per = (blink_reg == 0) ? 20'd1 : blink_reg;
    cmd_draws.delete();
    case (m)
      MODE_PUTCHAR: begin
        push_draw(CMD_SERIAL, 0, 0, 0, 0, 0, ch);
        if (!suspended) begin
          erase_underline();
          if (ch == CH_NEWLINE) advance_line();
          else if (ch == CH_RETURN) crs_col = 0;
          else begin
            push_draw(CMD_GLYPH, crs_col * CellW, crs_row * CellH, 0, 0, COLOR_FG, ch);
            crs_col = 8'(crs_col + 8'd1);
            if (crs_col >= cols_eff()) advance_line();
          end
          draw_underline();
          push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
        end
      end
      MODE_BACKSP: if (!suspended) begin
        erase_underline();
        if (crs_col > 0) begin
          crs_col = 8'(crs_col - 8'd1);
          push_draw(CMD_SERIAL, 0, 0, 0, 0, 0, CH_BACKSP);
          push_draw(CMD_SERIAL, 0, 0, 0, 0, 0, CH_SPACE);
          push_draw(CMD_SERIAL, 0, 0, 0, 0, 0, CH_BACKSP);
          push_draw(CMD_FILL, crs_col * CellW, crs_row * CellH, CellW, CellH, COLOR_BG, 0);
        end
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_SETPOS: if (!suspended) begin
        erase_underline();
        crs_col = clamp_cell(pc, cols_eff());
        crs_row = clamp_cell(pr, rows_eff());
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_CLEAR: if (!suspended) begin
        push_draw(CMD_CLEAR, 0, 0, 0, 0, COLOR_BG, 0);
        crs_col = 0;
        crs_row = 0;
        ul_drawn = 0;
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_CLRLINE: if (!suspended) begin
        erase_underline();
        px = crs_col * CellW;
        if (FRAME_WIDTH - px > 0)
          push_draw(CMD_FILL, px, crs_row * CellH, FRAME_WIDTH - px, CellH, COLOR_BG, 0);
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_ENABLE: if (!suspended) begin
        erase_underline();
        crs_enabled = en;
        crs_visible = en;
        blink_cnt = 0;
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_SHOW: if (!suspended && crs_enabled) begin
        erase_underline();
        crs_visible = 1;
        blink_cnt = 0;
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_HIDE: if (!suspended) begin
        erase_underline();
        crs_visible = 0;
        blink_cnt = 0;
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_TICK: if (!suspended && crs_enabled) begin
        blink_cnt = 20'(blink_cnt + 20'd1);
        if (blink_cnt >= per) begin
          blink_cnt = 0;
          if (crs_visible) begin
            erase_underline();
            crs_visible = 0;
          end else begin
            crs_visible = 1;
            draw_underline();
          end
          push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
        end
      end
      MODE_SUSPEND: if (!suspended) begin
        erase_underline();
        saved_vis = crs_visible;
        crs_visible = 0;
        blink_cnt = 0;
        ul_drawn = 0;
        suspended = 1;
        crs_col = 0;
        crs_row = 0;
        push_draw(CMD_CLEAR, 0, 0, 0, 0, COLOR_BG, 0);
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      MODE_RESUME: if (suspended) begin
        suspended = 0;
        crs_col = 0;
        crs_row = 0;
        ul_drawn = 0;
        blink_cnt = 0;
        crs_visible = crs_enabled && saved_vis;
        saved_vis = 0;
        push_draw(CMD_CLEAR, 0, 0, 0, 0, COLOR_BG, 0);
        draw_underline();
        push_draw(CMD_PRESENT, 0, 0, 0, 0, 0, 0);
      end
      default: ;
    endcase
    foreach (cmd_draws[k]) begin
      cmd_draws[k].col = crs_col;
      cmd_draws[k].row = crs_row;
      cmd_draws[k].last = (k == cmd_draws.size() - 1);
      expected_draws.push_back(cmd_draws[k]);
    end
  endtask

  task automatic note_failure(string what, draw_t exp_d, draw_t act_d);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s expected %p got %p", $realtime, what, exp_d, act_d);
  endtask

  always @(posedge clk) begin
    draw_t got, want;
    if (rst) begin
      columns_reg = 8'(FRAME_WIDTH / CellW);
      rows_reg = 8'(FRAME_HEIGHT / CellH);
      blink_reg = BLINK_RESET;
      crs_col = 0; crs_row = 0; ul_col = 0; ul_row = 0; saved_vis = 0;
      crs_enabled = 0; crs_visible = 0; ul_drawn = 0; suspended = 0;
      blink_cnt = 0;
      expected_draws.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{command, pixel_x, pixel_y, rect_width, rect_height, color, byte_out,
                cur_col, cur_row, last};
        if (expected_draws.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_draws.pop_front();
          if (got.command !== want.command || got.x !== want.x || got.y !== want.y ||
              got.w !== want.w || got.h !== want.h || got.color !== want.color ||
              got.byte_v !== want.byte_v || got.col !== want.col ||
              got.row !== want.row || got.last !== want.last)
            note_failure("mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: columns_reg = cfg_data[7:0];
          REG_ROWS:    rows_reg = cfg_data[7:0];
          REG_BLINK:   blink_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_command(mode, char_code, pos_col, pos_row, enable_flag);
    end
    pending <= expected_draws.size();
  end
endmodule

### test/tb_top.sv
// Top-level testbench for the text console cursor engine: clock, reset, stimulus,
// receiver stalls and verdict. Depends on tcc_pkg, the engine RTL and tcc_checker.
module tb_top;
  import tcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_data;
  logic in_valid, in_ready;
  logic [3:0] mode;
  logic [7:0] char_code;
  logic signed [15:0] pos_col, pos_row;
  logic enable_flag;
  logic out_valid, out_ready;
  logic [2:0] command;
  logic [11:0] pixel_x, pixel_y, rect_width;
  logic [4:0] rect_height;
  logic [23:0] color;
  logic [7:0] byte_out, cur_col, cur_row;
  logic last;
  int fail_count, pending;

  // Idle rates in percent for each side, changed per phase.
  int tx_idle, rx_idle;
  // One long receiver hold-off, requested once by the stimulus.
  logic hold_request, hold_taken;
  int hold_left, cycles;
  // Columns in force, used to aim set-position items near the edges.
  int cur_cols;

  typedef struct packed {
    logic [3:0] m;
    logic [7:0] ch;
    logic [15:0] pc;
    logic [15:0] pr;
    logic en;
  } cmd_item_t;

  text_console_cursor_engine uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .char_code, .pos_col, .pos_row, .enable_flag,
    .out_valid, .out_ready, .command, .pixel_x, .pixel_y, .rect_width,
    .rect_height, .color, .byte_out, .cur_col, .cur_row, .last
  );

  tcc_checker scoreboard (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .char_code, .pos_col, .pos_row, .enable_flag,
    .out_valid, .out_ready, .command, .pixel_x, .pixel_y, .rect_width,
    .rect_height, .color, .byte_out, .cur_col, .cur_row, .last,
    .fail_count, .pending
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls at rx_idle percent, plus one long hold-off so the
  // job queue fills and in_ready drops while the sender keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Offer one item; start right after an edge, return at the accepting edge
  // with valid still high so a following item keeps it up without a glitch.
  task automatic send_cmd(cmd_item_t it);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.m;
    char_code <= it.ch;
    pos_col <= it.pc;
    pos_row <= it.pr;
    enable_flag <= it.en;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic cmd_item_t mk(logic [3:0] m, logic [7:0] ch = 0, int pc = 0,
                                   int pr = 0, logic en = 0);
    cmd_item_t it;
    it.m = m;
    it.ch = ch;
    it.pc = pc[15:0];
    it.pr = pr[15:0];
    it.en = en;
    return it;
  endfunction

  // Drain everything, let the back end settle, then write all three registers.
  task automatic write_config(logic [7:0] cols, logic [7:0] rows, logic [19:0] period);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data <= {12'b0, cols};
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= {12'b0, rows};
    @(posedge clk);
    cfg_index <= REG_BLINK;
    cfg_data <= period;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cols = (cols == 0) ? 1 : cols;
  endtask

  // Mostly printing and cursor movement with random content; ticks, modes,
  // suspend/resume and unused codes mixed in.
  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int r;
    it = $bits(cmd_item_t)'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 40) begin
      it.m = MODE_PUTCHAR;
      case ($urandom_range(7))
        0: it.ch = CH_NEWLINE;
        1: it.ch = CH_RETURN;
        default: ;
      endcase
    end else if (r < 48) it.m = MODE_BACKSP;
    else if (r < 56) begin
      it.m = MODE_SETPOS;
      if ($urandom_range(1)) begin
        // Aim at the edges of the current screen.
        it.pc = 16'($urandom_range(cur_cols + 2)) - 16'd1;
        it.pr = 16'($urandom_range(8)) - 16'd1;
      end
    end
    else if (r < 59) it.m = MODE_CLEAR;
    else if (r < 64) it.m = MODE_CLRLINE;
    else if (r < 69) begin
      it.m = MODE_ENABLE;
      it.en = ($urandom_range(3) != 0);
    end
    else if (r < 72) it.m = MODE_SHOW;
    else if (r < 75) it.m = MODE_HIDE;
    else if (r < 90) it.m = MODE_TICK;
    else if (r < 93) it.m = MODE_SUSPEND;
    else if (r < 97) it.m = MODE_RESUME;
    else it.m = 4'($urandom_range(15, 11));
    return it;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_cmd(random_cmd());
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    cfg_we = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_PUTCHAR;
    char_code = '0;
    pos_col = '0;
    pos_row = '0;
    enable_flag = 1'b0;
    hold_request = 1'b0;
    tx_idle = 7;
    rx_idle = 52;
    cur_cols = 53;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a tiny 5x3 screen so wraps, scroll-clears and blinks come fast.
    write_config(8'd5, 8'd3, 20'd2);
    send_cmd(mk(MODE_ENABLE, 0, 0, 0, 1));
    send_cmd(mk(MODE_PUTCHAR, 8'd65));
    send_cmd(mk(MODE_PUTCHAR, 8'd0));
    send_cmd(mk(MODE_PUTCHAR, 8'd255));
    send_cmd(mk(MODE_PUTCHAR, CH_RETURN));
    send_cmd(mk(MODE_PUTCHAR, CH_NEWLINE));
    send_cmd(mk(MODE_PUTCHAR, CH_NEWLINE));       // reaches the last row
    repeat (5) send_cmd(mk(MODE_PUTCHAR, 8'd66)); // wraps at the right column
    send_cmd(mk(MODE_SETPOS, 0, -32768, -32768));
    send_cmd(mk(MODE_SETPOS, 0, 32767, 32767));
    send_cmd(mk(MODE_BACKSP));
    send_cmd(mk(MODE_SETPOS, 0, 0, 0));
    send_cmd(mk(MODE_BACKSP));                    // column zero: redraw only
    send_cmd(mk(MODE_CLRLINE));
    send_cmd(mk(MODE_TICK));
    send_cmd(mk(MODE_TICK));                      // period reached: toggle
    send_cmd(mk(MODE_HIDE));
    send_cmd(mk(MODE_SHOW));
    send_cmd(mk(MODE_SUSPEND));
    send_cmd(mk(MODE_PUTCHAR, 8'd67));            // serial byte only
    send_cmd(mk(MODE_BACKSP));                    // dropped while suspended
    send_cmd(mk(MODE_RESUME));
    send_cmd(mk(MODE_CLEAR));
    send_cmd(mk(MODE_ENABLE, 0, 0, 0, 0));
    send_cmd(mk(MODE_TICK));                      // disabled: nothing
    send_cmd(mk(MODE_SHOW));                      // disabled: nothing
    send_cmd(mk(4'd15));                          // unused code

    // Widest screen: clear-line past the frame edge, blink never expires.
    write_config(8'd255, 8'd255, 20'hFFFFF);
    random_phase(95);

    // Register value zero: one cell screen, blink period one.
    tx_idle = 52;
    rx_idle = 7;
    write_config(8'd0, 8'd0, 20'd0);
    random_phase(90);

    // Full speed on both sides, one long receiver hold-off to back up the queue.
    tx_idle = 0;
    rx_idle = 0;
    write_config(8'd12, 8'd5, 20'd3);
    hold_request <= 1'b1;
    random_phase(100);

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
